>>> sv/i2c_rts_pkg.sv
package i2c_rts_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  slave_address;
        logic [15:0] reg_address;
        logic [7:0]  size;
        logic [7:0]  write_byte;
        logic [3:0]  byte_index;
        logic        engine_flag;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
        logic        sda_high;
    } in_item_t;

    typedef struct packed {
        logic [2:0] engine_command;
        logic [7:0] tx_byte;
        logic [7:0] reply_count;
        logic       reply_error;
        logic [7:0] read_byte;
        logic       last;
        logic [3:0] phase;
    } out_item_t;

    localparam logic [2:0] MODE_READ  = 3'd0;
    localparam logic [2:0] MODE_WRITE = 3'd1;
    localparam logic [2:0] MODE_LOAD  = 3'd2;
    localparam logic [2:0] MODE_EVENT = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    localparam logic [3:0] PH_DONE     = 4'd0;
    localparam logic [3:0] PH_IDLE     = 4'd1;
    localparam logic [3:0] PH_INIT     = 4'd2;
    localparam logic [3:0] PH_START    = 4'd3;
    localparam logic [3:0] PH_SLAW     = 4'd4;
    localparam logic [3:0] PH_ADRH     = 4'd5;
    localparam logic [3:0] PH_ADRL     = 4'd6;
    localparam logic [3:0] PH_RESTART  = 4'd7;
    localparam logic [3:0] PH_SLAR     = 4'd8;
    localparam logic [3:0] PH_RX       = 4'd9;
    localparam logic [3:0] PH_TX       = 4'd10;
    localparam logic [3:0] PH_ERR      = 4'd11;
    localparam logic [3:0] PH_BRESET   = 4'd12;
    localparam logic [3:0] PH_BRELEASE = 4'd13;

    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_REP_START   = 8'h10;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_W_ADR_ACK   = 8'h18;
    localparam logic [7:0] ST_W_ADR_NACK  = 8'h20;
    localparam logic [7:0] ST_W_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_R_ADR_ACK   = 8'h40;
    localparam logic [7:0] ST_R_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_R_DATA_NACK = 8'h58;
    localparam logic [7:0] BUS_IDLE_BYTE  = 8'hFF;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_SEND      = 3'd2;
    localparam logic [2:0] CMD_RX_ACK    = 3'd3;
    localparam logic [2:0] CMD_RX_NACK   = 3'd4;
    localparam logic [2:0] CMD_STOP      = 3'd5;
    localparam logic [2:0] CMD_REL_START = 3'd6;

    localparam int MAX_OUT = 16;

    localparam logic CFG_TRANSFER = 1'b0;
    localparam logic CFG_RECOVERY = 1'b1;

    // buffer access request from the control unit
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [5:0] rd_addr;
    } buf_req_t;

endpackage

>>> sv/i2c_register_transfer_sequencer_top.sv
// Register-transfer sequencer for an I2C master above a byte-level bus engine. Each input
// item (call, staged byte, bus event or tick) yields one result, except a read poll, which
// streams its buffered bytes one at a time from the data memory (separate write and read
// ports, registered read) while the input stalls. A write-phase data send also waits on
// the buffer read for its byte. Config writes: index 0 transfer timeout, 1 recovery
// timeout.
module i2c_register_transfer_sequencer_top #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  i2c_rts_pkg::in_item_t  in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output i2c_rts_pkg::out_item_t out_item,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data
);
    import i2c_rts_pkg::*;

    buf_req_t   breq;
    logic [7:0] rd_data;

    i2c_rts_ctrl #(.DEPTH(BUFFER_DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .breq      (breq),
        .rd_data   (rd_data)
    );

    i2c_rts_buffer #(.DEPTH(BUFFER_DEPTH)) u_buf (
        .clk     (clk),
        .req     (breq),
        .rd_data (rd_data)
    );

`ifndef SYNTH
    a_no_same_cycle_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(breq.wr_en && breq.rd_en))
        else $error("buffer read and write in one cycle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");
    a_idle_no_stall_engine: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.mode == MODE_LOAD |=> !in_stall || out_stall)
        else $error("staging item blocked input");
`endif

endmodule

>>> sv/i2c_rts_buffer.sv
module i2c_rts_buffer #(
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  i2c_rts_pkg::buf_req_t req,
    output logic [7:0]            rd_data
);
    import i2c_rts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr[AW-1:0]];
        end
    end

endmodule

>>> sv/i2c_rts_ctrl.sv
module i2c_rts_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  i2c_rts_pkg::in_item_t  in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output i2c_rts_pkg::out_item_t out_item,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data,
    output i2c_rts_pkg::buf_req_t  breq,
    input  logic [7:0]             rd_data
);
    import i2c_rts_pkg::*;

    localparam int CLAMP = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;
    localparam logic [6:0] DEPTH_W = 7'(DEPTH);
    localparam logic [7:0] CLAMP_B = 8'(CLAMP);

    typedef enum logic [1:0] {S_RUN, S_FETCH, S_STREAM} ctl_t;

    ctl_t        ctl_reg, ctl_next;
    logic [3:0]  st_reg, st_next;
    logic [6:0]  len_reg, len_next;
    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  slv_reg, slv_next;
    logic        wr_reg, wr_next;
    logic [15:0] radr_reg, radr_next;
    logic [15:0] tmo_reg, tmo_next;
    logic [15:0] rec_reg, rec_next;
    logic [15:0] ttk_reg, rtk_reg;
    logic        ov_reg, ov_next;
    out_item_t   oi_reg, oi_next;
    logic [4:0]  k_reg, k_next;
    logic [4:0]  n_reg, n_next;
    // tx_data send waits on the buffer read
    logic        txw_reg, txw_next;

    logic        busy;
    logic        match;
    logic [7:0]  sz;
    logic [2:0]  cmd;
    logic [7:0]  txb;
    logic [7:0]  cnt;
    logic        err;
    logic        acc;
    logic        slot;

    assign slot = !ov_reg || !out_stall;
    assign in_stall = (ctl_reg != S_RUN) || !slot;
    assign acc = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_item = oi_reg;
    assign sz = in_item.size;
    assign match = (in_item.slave_address == slv_reg)
                   && (wr_reg == (in_item.mode == MODE_WRITE));
    assign busy = 1'b0;

    always_comb
    begin
        ctl_next = ctl_reg;
        st_next = st_reg;
        len_next = len_reg;
        pos_next = pos_reg;
        slv_next = slv_reg;
        wr_next = wr_reg;
        radr_next = radr_reg;
        tmo_next = tmo_reg;
        rec_next = rec_reg;
        ov_next = ov_reg && out_stall;
        oi_next = oi_reg;
        k_next = k_reg;
        n_next = n_reg;
        txw_next = 1'b0;
        cmd = CMD_NONE;
        txb = 8'h00;
        cnt = 8'h00;
        err = 1'b0;
        breq = '0;
        case (ctl_reg)
            S_RUN:
            begin
                if (acc)
                begin
                    n_next = 5'd0;
                    case (in_item.mode)
                        MODE_READ, MODE_WRITE:
                        begin
                            case (st_reg)
                                PH_IDLE:
                                begin
                                    if (sz != 8'd0 && sz <= 8'(DEPTH))
                                    begin
                                        wr_next = in_item.mode[0];
                                        slv_next = in_item.slave_address;
                                        radr_next = in_item.reg_address;
                                        len_next = sz[6:0];
                                        st_next = PH_START;
                                        cmd = CMD_START;
                                        tmo_next = ttk_reg;
                                    end
                                    else
                                    begin
                                        err = 1'b1;
                                    end
                                end
                                PH_DONE:
                                begin
                                    if (match)
                                    begin
                                        if (in_item.mode[0])
                                        begin
                                            cnt = sz;
                                        end
                                        else
                                        begin
                                            cnt = (sz > CLAMP_B) ? CLAMP_B : sz;
                                            n_next = cnt[4:0];
                                        end
                                        st_next = PH_IDLE;
                                    end
                                    else if (tmo_reg == 16'd0)
                                    begin
                                        st_next = PH_IDLE;
                                    end
                                end
                                PH_ERR:
                                begin
                                    if (match || tmo_reg == 16'd0)
                                    begin
                                        err = match;
                                        cmd = CMD_REL_START;
                                        tmo_next = ttk_reg;
                                        st_next = PH_BRESET;
                                    end
                                end
                                PH_INIT:
                                begin
                                end
                                default:
                                begin
                                    if (tmo_reg == 16'd0)
                                    begin
                                        st_next = PH_ERR;
                                    end
                                end
                            endcase
                        end
                        MODE_LOAD:
                        begin
                            if (st_reg == PH_IDLE && 7'(in_item.byte_index) < DEPTH_W)
                            begin
                                breq.wr_en = 1'b1;
                                breq.wr_addr = 6'(in_item.byte_index);
                                breq.wr_data = in_item.write_byte;
                            end
                        end
                        MODE_EVENT:
                        begin
                            if (st_reg == PH_INIT)
                            begin
                                if (!in_item.engine_flag)
                                begin
                                    st_next = PH_IDLE;
                                end
                            end
                            else if (st_reg == PH_IDLE)
                            begin
                                if (in_item.sda_high)
                                begin
                                    rec_next = rtk_reg;
                                end
                                else if (rec_reg == 16'd0)
                                begin
                                    cmd = CMD_REL_START;
                                    tmo_next = ttk_reg;
                                    rec_next = rtk_reg;
                                    st_next = PH_BRESET;
                                end
                            end
                            else if (in_item.engine_flag)
                            begin
                                case (st_reg)
                                    PH_BRESET:
                                    begin
                                        if (in_item.bus_status inside {ST_START, ST_REP_START})
                                        begin
                                            cmd = CMD_SEND;
                                            txb = BUS_IDLE_BYTE;
                                        end
                                        st_next = PH_BRELEASE;
                                    end
                                    PH_BRELEASE:
                                    begin
                                        cmd = CMD_STOP;
                                        st_next = PH_IDLE;
                                    end
                                    PH_START:
                                    begin
                                        if (in_item.bus_status inside {ST_START, ST_REP_START})
                                        begin
                                            cmd = CMD_SEND;
                                            txb = {slv_reg, 1'b0};
                                            pos_next = 7'd0;
                                            st_next = PH_SLAW;
                                        end
                                        else
                                        begin
                                            st_next = PH_ERR;
                                        end
                                    end
                                    PH_SLAW:
                                    begin
                                        if (in_item.bus_status == ST_W_ADR_ACK)
                                        begin
                                            cmd = CMD_SEND;
                                            txb = radr_reg[15:8];
                                            st_next = PH_ADRH;
                                        end
                                        else if (in_item.bus_status inside
                                                 {ST_W_ADR_NACK, ST_ARB_LOST})
                                        begin
                                            cmd = CMD_START;
                                            if (in_item.bus_status == ST_W_ADR_NACK)
                                            begin
                                                pos_next = 7'd0;
                                            end
                                            st_next = PH_START;
                                        end
                                        else
                                        begin
                                            st_next = PH_ERR;
                                        end
                                    end
                                    PH_ADRH, PH_ADRL:
                                    begin
                                        if (in_item.bus_status == ST_W_DATA_ACK)
                                        begin
                                            if (st_reg == PH_ADRH)
                                            begin
                                                cmd = CMD_SEND;
                                                txb = radr_reg[7:0];
                                                st_next = PH_ADRL;
                                            end
                                            else if (!wr_reg)
                                            begin
                                                cmd = CMD_START;
                                                st_next = PH_RESTART;
                                            end
                                            else
                                            begin
                                                st_next = PH_TX;
                                            end
                                        end
                                        else if (in_item.bus_status == ST_ARB_LOST)
                                        begin
                                            cmd = CMD_START;
                                            st_next = PH_START;
                                        end
                                        else
                                        begin
                                            st_next = PH_ERR;
                                        end
                                    end
                                    PH_RESTART:
                                    begin
                                        if (in_item.bus_status == ST_REP_START)
                                        begin
                                            cmd = CMD_SEND;
                                            txb = {slv_reg, 1'b1};
                                            st_next = PH_SLAR;
                                        end
                                        else
                                        begin
                                            st_next = PH_ERR;
                                        end
                                    end
                                    PH_SLAR:
                                    begin
                                        if (in_item.bus_status == ST_R_ADR_ACK)
                                        begin
                                            cmd = (pos_reg + 7'd1 < len_reg)
                                                  ? CMD_RX_ACK : CMD_RX_NACK;
                                            st_next = PH_RX;
                                        end
                                        else
                                        begin
                                            st_next = PH_ERR;
                                        end
                                    end
                                    PH_RX:
                                    begin
                                        if (in_item.bus_status inside
                                            {ST_R_DATA_ACK, ST_R_DATA_NACK})
                                        begin
                                            if (pos_reg < DEPTH_W)
                                            begin
                                                breq.wr_en = 1'b1;
                                                breq.wr_addr = pos_reg[5:0];
                                                breq.wr_data = in_item.rx_byte;
                                                pos_next = pos_reg + 7'd1;
                                            end
                                            if (in_item.bus_status == ST_R_DATA_ACK)
                                            begin
                                                cmd = (pos_next + 7'd1 < len_reg)
                                                      ? CMD_RX_ACK : CMD_RX_NACK;
                                            end
                                            else
                                            begin
                                                cmd = CMD_STOP;
                                                st_next = PH_DONE;
                                            end
                                        end
                                        else
                                        begin
                                            st_next = PH_ERR;
                                        end
                                    end
                                    PH_TX:
                                    begin
                                        if (in_item.bus_status == ST_W_DATA_ACK)
                                        begin
                                            if (pos_reg < len_reg && pos_reg < DEPTH_W)
                                            begin
                                                // byte comes from memory next cycle
                                                cmd = CMD_SEND;
                                                breq.rd_en = 1'b1;
                                                breq.rd_addr = pos_reg[5:0];
                                                pos_next = pos_reg + 7'd1;
                                                txw_next = 1'b1;
                                            end
                                            else
                                            begin
                                                cmd = CMD_STOP;
                                                st_next = PH_DONE;
                                            end
                                        end
                                        else if (in_item.bus_status == ST_ARB_LOST)
                                        begin
                                            cmd = CMD_START;
                                            st_next = PH_START;
                                        end
                                        else
                                        begin
                                            st_next = PH_ERR;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        MODE_TICK:
                        begin
                            if (tmo_reg != 16'd0)
                            begin
                                tmo_next = tmo_reg - 16'd1;
                            end
                            if (rec_reg != 16'd0)
                            begin
                                rec_next = rec_reg - 16'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    oi_next.engine_command = cmd;
                    oi_next.tx_byte = txb;
                    oi_next.reply_count = cnt;
                    oi_next.reply_error = err;
                    oi_next.read_byte = 8'h00;
                    oi_next.phase = st_next;
                    oi_next.last = 1'b1;
                    if (n_next != 5'd0 || txw_next)
                    begin
                        // result waits for buffer data
                        if (n_next != 5'd0)
                        begin
                            breq.rd_en = 1'b1;
                            breq.rd_addr = 6'd0;
                        end
                        k_next = 5'd0;
                        ctl_next = S_FETCH;
                    end
                    else
                    begin
                        ov_next = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                // read data valid now; hold until the output slot frees
                if (slot)
                begin
                    ov_next = 1'b1;
                    if (txw_reg)
                    begin
                        oi_next.tx_byte = rd_data;
                        ctl_next = S_RUN;
                    end
                    else
                    begin
                        oi_next.read_byte = rd_data;
                        oi_next.last = (k_reg + 5'd1 == n_reg);
                        k_next = k_reg + 5'd1;
                        if (k_reg + 5'd1 == n_reg)
                        begin
                            ctl_next = S_RUN;
                        end
                        else
                        begin
                            breq.rd_en = 1'b1;
                            breq.rd_addr = 6'(k_reg + 5'd1);
                            ctl_next = S_STREAM;
                        end
                    end
                end
                else
                begin
                    txw_next = txw_reg;
                end
            end
            S_STREAM:
            begin
                // wait state for the next buffer read
                ctl_next = S_FETCH;
            end
            default:
            begin
                ctl_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= S_RUN;
            st_reg <= PH_INIT;
            len_reg <= '0;
            pos_reg <= '0;
            slv_reg <= '0;
            wr_reg <= 1'b0;
            radr_reg <= '0;
            tmo_reg <= '0;
            rec_reg <= 16'd1000;
            ttk_reg <= 16'd200;
            rtk_reg <= 16'd1000;
            ov_reg <= 1'b0;
            k_reg <= '0;
            n_reg <= '0;
            txw_reg <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            st_reg <= st_next;
            len_reg <= len_next;
            pos_reg <= pos_next;
            slv_reg <= slv_next;
            wr_reg <= wr_next;
            radr_reg <= radr_next;
            tmo_reg <= tmo_next;
            rec_reg <= rec_next;
            ov_reg <= ov_next;
            k_reg <= k_next;
            n_reg <= n_next;
            txw_reg <= txw_next;
            if (cfg_we && !busy)
            begin
                if (cfg_index == CFG_TRANSFER)
                begin
                    ttk_reg <= cfg_data;
                end
                else
                begin
                    rtk_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oi_reg <= oi_next;
    end

endmodule

>>> bench/i2c_register_transfer_sequencer_top_tb.sv
`timescale 1ns / 100ps

module i2c_register_transfer_sequencer_top_tb;
    import i2c_rts_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_we;
    logic cfg_index;
    logic [15:0] cfg_data;

    i2c_register_transfer_sequencer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // sequencer shadow state
    logic [3:0] seq_ph;
    logic [7:0] buf_mem [DEPTH];
    int xfer_len;
    int buf_pos;
    logic [6:0] act_slave;
    logic act_write;
    logic [15:0] act_reg;
    int tmo_left;
    int rec_left;
    int tmo_reg;
    int rec_reg;

    out_item_t pending_results[$];
    int errors;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall, with a long hold-off on request
    always @(negedge clk) begin
        if (hold_off > 0) begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", out_item);
            end
            else begin
                want = pending_results.pop_front();
                if (want.engine_command !== out_item.engine_command
                    || want.tx_byte !== out_item.tx_byte
                    || want.reply_count !== out_item.reply_count
                    || want.reply_error !== out_item.reply_error
                    || want.read_byte !== out_item.read_byte
                    || want.last !== out_item.last
                    || want.phase !== out_item.phase) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p got %p", want, out_item);
                end
            end
        end
    end

    function automatic logic [2:0] rx_cmd();
        return (buf_pos + 1 < xfer_len) ? CMD_RX_ACK : CMD_RX_NACK;
    endfunction

    // computes the results the sequencer owes for one item
    function automatic void predict_results(in_item_t x);
        logic [2:0] cmd;
        logic [7:0] txb;
        int cnt;
        logic err;
        int nbytes;
        int nres;
        bit match;
        bit poll;
        logic [3:0] pre;
        out_item_t r;
        cmd = CMD_NONE;
        txb = 8'd0;
        cnt = 0;
        err = 1'b0;
        nbytes = 0;
        pre = seq_ph;
        case (x.mode)
            MODE_READ, MODE_WRITE: begin
                match = (x.slave_address == act_slave) && (act_write == x.mode[0]);
                poll = (pre == PH_DONE) && (x.mode == MODE_READ) && !act_write
                    && (x.slave_address == act_slave);
                case (seq_ph)
                    PH_IDLE: begin
                        if (x.size > 0 && x.size <= DEPTH) begin
                            act_write = x.mode[0];
                            act_slave = x.slave_address;
                            act_reg = x.reg_address;
                            xfer_len = x.size;
                            seq_ph = PH_START;
                            cmd = CMD_START;
                            tmo_left = tmo_reg;
                        end
                        else
                            err = 1'b1;
                    end
                    PH_DONE: begin
                        if (match) begin
                            if (x.mode == MODE_WRITE)
                                cnt = x.size;
                            seq_ph = PH_IDLE;
                        end
                        else if (tmo_left == 0)
                            seq_ph = PH_IDLE;
                    end
                    PH_ERR: begin
                        if (match || tmo_left == 0) begin
                            err = match;
                            cmd = CMD_REL_START;
                            tmo_left = tmo_reg;
                            seq_ph = PH_BRESET;
                        end
                    end
                    PH_INIT: ;
                    default: if (tmo_left == 0) seq_ph = PH_ERR;
                endcase
                if (poll) begin
                    nbytes = (x.size > MAX_OUT) ? MAX_OUT : x.size;
                    cnt = nbytes;
                end
            end
            MODE_LOAD: if (seq_ph == PH_IDLE) buf_mem[x.byte_index] = x.write_byte;
            MODE_EVENT: begin
                if (seq_ph == PH_INIT) begin
                    if (!x.engine_flag)
                        seq_ph = PH_IDLE;
                end
                else if (seq_ph == PH_IDLE) begin
                    if (x.sda_high)
                        rec_left = rec_reg;
                    else if (rec_left == 0) begin
                        cmd = CMD_REL_START;
                        tmo_left = tmo_reg;
                        rec_left = rec_reg;
                        seq_ph = PH_BRESET;
                    end
                end
                else if (x.engine_flag) begin
                    case (seq_ph)
                        PH_BRESET: begin
                            if (x.bus_status == ST_START || x.bus_status == ST_REP_START)
                            begin
                                cmd = CMD_SEND;
                                txb = BUS_IDLE_BYTE;
                            end
                            seq_ph = PH_BRELEASE;
                        end
                        PH_BRELEASE: begin
                            cmd = CMD_STOP;
                            seq_ph = PH_IDLE;
                        end
                        PH_START: begin
                            if (x.bus_status == ST_START || x.bus_status == ST_REP_START)
                            begin
                                cmd = CMD_SEND;
                                txb = {act_slave, 1'b0};
                                buf_pos = 0;
                                seq_ph = PH_SLAW;
                            end
                            else
                                seq_ph = PH_ERR;
                        end
                        PH_SLAW: begin
                            if (x.bus_status == ST_W_ADR_ACK) begin
                                cmd = CMD_SEND;
                                txb = act_reg[15:8];
                                seq_ph = PH_ADRH;
                            end
                            else if (x.bus_status == ST_W_ADR_NACK
                                     || x.bus_status == ST_ARB_LOST) begin
                                cmd = CMD_START;
                                if (x.bus_status == ST_W_ADR_NACK)
                                    buf_pos = 0;
                                seq_ph = PH_START;
                            end
                            else
                                seq_ph = PH_ERR;
                        end
                        PH_ADRH, PH_ADRL: begin
                            if (x.bus_status == ST_W_DATA_ACK) begin
                                if (seq_ph == PH_ADRH) begin
                                    cmd = CMD_SEND;
                                    txb = act_reg[7:0];
                                    seq_ph = PH_ADRL;
                                end
                                else if (!act_write) begin
                                    cmd = CMD_START;
                                    seq_ph = PH_RESTART;
                                end
                                else
                                    seq_ph = PH_TX;
                            end
                            else if (x.bus_status == ST_ARB_LOST) begin
                                cmd = CMD_START;
                                seq_ph = PH_START;
                            end
                            else
                                seq_ph = PH_ERR;
                        end
                        PH_RESTART: begin
                            if (x.bus_status == ST_REP_START) begin
                                cmd = CMD_SEND;
                                txb = {act_slave, 1'b1};
                                seq_ph = PH_SLAR;
                            end
                            else
                                seq_ph = PH_ERR;
                        end
                        PH_SLAR: begin
                            if (x.bus_status == ST_R_ADR_ACK) begin
                                cmd = rx_cmd();
                                seq_ph = PH_RX;
                            end
                            else
                                seq_ph = PH_ERR;
                        end
                        PH_RX: begin
                            if (x.bus_status == ST_R_DATA_ACK
                                || x.bus_status == ST_R_DATA_NACK) begin
                                if (buf_pos < DEPTH) begin
                                    buf_mem[buf_pos] = x.rx_byte;
                                    buf_pos++;
                                end
                                if (x.bus_status == ST_R_DATA_ACK)
                                    cmd = rx_cmd();
                                else begin
                                    cmd = CMD_STOP;
                                    seq_ph = PH_DONE;
                                end
                            end
                            else
                                seq_ph = PH_ERR;
                        end
                        PH_TX: begin
                            if (x.bus_status == ST_W_DATA_ACK) begin
                                if (buf_pos < xfer_len && buf_pos < DEPTH) begin
                                    cmd = CMD_SEND;
                                    txb = buf_mem[buf_pos];
                                    buf_pos++;
                                end
                                else begin
                                    cmd = CMD_STOP;
                                    seq_ph = PH_DONE;
                                end
                            end
                            else if (x.bus_status == ST_ARB_LOST) begin
                                cmd = CMD_START;
                                seq_ph = PH_START;
                            end
                            else
                                seq_ph = PH_ERR;
                        end
                        default: ;
                    endcase
                end
            end
            MODE_TICK: begin
                if (tmo_left > 0)
                    tmo_left--;
                if (rec_left > 0)
                    rec_left--;
            end
            default: ;
        endcase
        nres = (nbytes > 0) ? nbytes : 1;
        for (int k = 0; k < nres; k++) begin
            r.engine_command = cmd;
            r.tx_byte = txb;
            r.reply_count = cnt[7:0];
            r.reply_error = err;
            r.read_byte = (nbytes > 0) ? buf_mem[k] : 8'd0;
            r.last = (k + 1 == nres);
            r.phase = seq_ph;
            pending_results.push_back(r);
        end
    endfunction

    task automatic send_item(in_item_t x);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_results(x);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TRANSFER)
            tmo_reg = val;
        else
            rec_reg = val;
    endtask

    function automatic in_item_t op(logic [2:0] m, logic [6:0] sla, logic [15:0] ra,
                                    logic [7:0] sz);
        in_item_t x;
        x = '0;
        x.mode = m;
        x.slave_address = sla;
        x.reg_address = ra;
        x.size = sz;
        x.sda_high = 1'b1;
        return x;
    endfunction

    function automatic in_item_t bus_ev(logic [7:0] st, logic [7:0] rxb);
        in_item_t x;
        x = op(MODE_EVENT, 7'd0, 16'd0, 8'd0);
        x.engine_flag = 1'b1;
        x.bus_status = st;
        x.rx_byte = rxb;
        return x;
    endfunction

    function automatic logic [7:0] good_status();
        case (seq_ph)
            PH_START: return $urandom_range(0, 1) ? ST_START : ST_REP_START;
            PH_SLAW: begin
                case ($urandom_range(0, 9))
                    0: return ST_W_ADR_NACK;
                    1: return ST_ARB_LOST;
                    default: return ST_W_ADR_ACK;
                endcase
            end
            PH_ADRH, PH_ADRL, PH_TX:
                return ($urandom_range(0, 11) == 0) ? ST_ARB_LOST : ST_W_DATA_ACK;
            PH_RESTART: return ST_REP_START;
            PH_SLAR: return ST_R_ADR_ACK;
            PH_RX: return (buf_pos + 1 < xfer_len) ? ST_R_DATA_ACK : ST_R_DATA_NACK;
            PH_BRESET: return ST_START;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly well-formed transfers steered by the shadow state, some noise
    function automatic in_item_t next_random_item();
        in_item_t x;
        int r;
        r = $urandom_range(0, 99);
        x = {$urandom, $urandom};
        if (r < 12)
            return x;
        x.mode = MODE_TICK;
        case (seq_ph)
            PH_INIT: begin
                x.mode = MODE_EVENT;
                x.engine_flag = 1'b0;
            end
            PH_IDLE: begin
                if (r < 55) begin
                    x.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
                    if ($urandom_range(0, 3) == 0)
                        x.slave_address = act_slave;
                    x.size = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'd0
                        : 8'($urandom_range(17, 255)))
                        : ($urandom_range(0, 4) == 0 ? 8'($urandom_range(1, 16))
                        : 8'($urandom_range(1, 4)));
                end
                else if (r < 70)
                    x.mode = MODE_LOAD;
                else if (r < 85)
                    x.mode = MODE_EVENT;
            end
            PH_DONE, PH_ERR: begin
                if (r < 75) begin
                    x.mode = act_write ? MODE_WRITE : MODE_READ;
                    x.slave_address = act_slave;
                    if ($urandom_range(0, 1))
                        x.size = 8'($urandom_range(0, 17));
                end
            end
            default: begin
                if (r < 88) begin
                    x.mode = MODE_EVENT;
                    x.engine_flag = 1'b1;
                    x.bus_status = good_status();
                end
                else if (r < 93) begin
                    x.mode = MODE_EVENT;
                    x.engine_flag = 1'b1;
                end
            end
        endcase
        return x;
    endfunction

    task automatic test_bring_up();
        in_item_t x;
        send_item(bus_ev(8'd0, 8'd0));
        send_item(op(MODE_TICK, 7'd0, 16'd0, 8'd0));
        x = op(MODE_EVENT, 7'd0, 16'd0, 8'd0);
        send_item(x);
        // every buffer entry gets a value before anything can poll it
        for (int i = 0; i < DEPTH; i++) begin
            x = op(MODE_LOAD, 7'd0, 16'd0, 8'd0);
            x.byte_index = 4'(i);
            x.write_byte = 8'($urandom);
            send_item(x);
        end
    endtask

    task automatic test_directed_read();
        send_item(op(MODE_READ, 7'h7F, 16'hFFFF, 8'd2));
        send_item(bus_ev(ST_START, 8'd0));
        send_item(bus_ev(ST_W_ADR_ACK, 8'd0));
        send_item(bus_ev(ST_W_DATA_ACK, 8'd0));
        send_item(bus_ev(ST_W_DATA_ACK, 8'd0));
        send_item(bus_ev(ST_REP_START, 8'd0));
        send_item(bus_ev(ST_R_ADR_ACK, 8'd0));
        send_item(bus_ev(ST_R_DATA_ACK, 8'hFF));
        send_item(bus_ev(ST_R_DATA_NACK, 8'h00));
        // oversized poll is clamped
        send_item(op(MODE_READ, 7'h7F, 16'd0, 8'hFF));
    endtask

    task automatic test_directed_write();
        send_item(op(MODE_READ, 7'd0, 16'd0, 8'd0));
        send_item(op(MODE_WRITE, 7'd0, 16'd0, 8'd17));
        send_item(op(3'd5, 7'd0, 16'd0, 8'd0));
        send_item(op(3'd7, 7'h7F, 16'hFFFF, 8'hFF));
        send_item(op(MODE_WRITE, 7'd0, 16'h0000, 8'd1));
        send_item(bus_ev(ST_REP_START, 8'd0));
        send_item(bus_ev(ST_W_ADR_NACK, 8'd0));
        send_item(bus_ev(ST_START, 8'd0));
        send_item(bus_ev(ST_W_ADR_ACK, 8'd0));
        send_item(bus_ev(ST_W_DATA_ACK, 8'd0));
        send_item(bus_ev(ST_W_DATA_ACK, 8'd0));
        send_item(bus_ev(ST_W_DATA_ACK, 8'd0));
        send_item(bus_ev(ST_W_DATA_ACK, 8'd0));
        send_item(bus_ev(ST_W_DATA_ACK, 8'd0));
        send_item(op(MODE_WRITE, 7'd0, 16'd0, 8'd9));
    endtask

    task automatic test_bus_recovery();
        in_item_t x;
        drain();
        write_cfg(CFG_RECOVERY, 16'd1);
        write_cfg(CFG_TRANSFER, 16'd1);
        send_item(bus_ev(8'd0, 8'd0));
        send_item(op(MODE_TICK, 7'd0, 16'd0, 8'd0));
        x = op(MODE_EVENT, 7'd0, 16'd0, 8'd0);
        x.sda_high = 1'b0;
        send_item(x);
        send_item(bus_ev(ST_START, 8'd0));
        send_item(bus_ev(8'd0, 8'd0));
        // an unexpected status sends the transfer to error, then a timeout clears it
        send_item(op(MODE_READ, 7'd3, 16'h1234, 8'd1));
        send_item(bus_ev(ST_R_DATA_ACK, 8'd0));
        send_item(op(MODE_TICK, 7'd0, 16'd0, 8'd0));
        send_item(op(MODE_WRITE, 7'd9, 16'd0, 8'd1));
        send_item(bus_ev(ST_START, 8'd0));
        send_item(bus_ev(ST_START, 8'd0));
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            send_item(next_random_item());
    endtask

    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // hold-off counter is set at the rising edge, apart from the falling-edge block that counts it down
        in_valid <= 1'b0;
        @(posedge clk);
        hold_off <= 300;
        @(negedge clk);
        for (int i = 0; i < 40; i++)
            send_item(next_random_item());
        // sender waits for the block to empty completely
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
        for (int i = 0; i < 20; i++)
            send_item(next_random_item());
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TRANSFER;
        cfg_data = 16'd0;
        errors = 0;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        seq_ph = PH_INIT;
        xfer_len = 0;
        buf_pos = 0;
        act_slave = '0;
        act_write = 1'b0;
        act_reg = '0;
        tmo_left = 0;
        tmo_reg = 200;
        rec_reg = 1000;
        rec_left = 1000;
        foreach (buf_mem[i])
            buf_mem[i] = 8'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_bring_up();
        test_directed_read();
        test_directed_write();
        test_bus_recovery();
        test_random(80, 0, 0);
        drain();
        write_cfg(CFG_TRANSFER, 16'd3);
        write_cfg(CFG_RECOVERY, 16'd2);
        test_random(80, 57, 0);
        drain();
        write_cfg(CFG_TRANSFER, 16'hFFFF);
        write_cfg(CFG_RECOVERY, 16'hFFFF);
        test_random(80, 0, 57);
        test_back_pressure();
        drain();
        write_cfg(CFG_TRANSFER, 16'd40);
        write_cfg(CFG_RECOVERY, 16'd5);
        test_random(80, 23, 23);

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
